FILE: rtl/core/metropolis_spin_flip_decision_assert.svh
// Assertion macros for the spin flip decision block.
// Included by the top level; define NO_ASSERTIONS to compile them away.
`ifndef METROPOLIS_SPIN_FLIP_DECISION_ASSERT_SVH
`define METROPOLIS_SPIN_FLIP_DECISION_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define MSSF_ASSERT(lbl, clk_sig, rst_n_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error("spin flip decision: assertion failed");
// Condition that must never be true outside reset.
`define MSSF_ASSERT_NEVER(lbl, clk_sig, rst_n_sig, expr) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(expr)) \
		else $error("spin flip decision: forbidden condition");
`else
`define MSSF_ASSERT(lbl, clk_sig, rst_n_sig, prop)
`define MSSF_ASSERT_NEVER(lbl, clk_sig, rst_n_sig, expr)
`endif
`endif

FILE: rtl/core/mssf_pkg.sv
// Shared constants, register codes and beat types of the spin flip decision.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps

package mssf_pkg;

	// Field and register widths.
	localparam int NBR_WIDTH     = 8;
	localparam int MAX_NEIGHBORS = 8;
	localparam int NBR_LIMIT     = (MAX_NEIGHBORS < NBR_WIDTH) ? MAX_NEIGHBORS : NBR_WIDTH;
	localparam int UNIFORM_W     = 32;
	localparam int COUNT_W       = 4;
	localparam int COUPLING_W    = 16;
	localparam int BETA_W        = 16;
	localparam int CFG_DATA_W    = 16;
	localparam int CFG_INDEX_W   = 2;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_NEIGHBOR_COUNT = 2'd0,
		CFG_COUPLING_J2    = 2'd1,
		CFG_INVERSE_TEMP   = 2'd2
	} cfg_index_t;

	// Register reset values.
	localparam logic [COUNT_W-1:0]           COUNT_RESET    = 4'd4;
	localparam logic signed [COUPLING_W-1:0] COUPLING_RESET = 16'sd0;
	localparam logic [BETA_W-1:0]            BETA_RESET     = 16'd4096;

	// Energy arithmetic: one bond term, the delta sum and the exponent argument.
	localparam int WT_W    = COUPLING_W + 1;
	localparam int DELTA_W = WT_W + 3;
	localparam int MAG_W   = DELTA_W - 1;
	localparam int X_W     = BETA_W + MAG_W + 1;
	localparam logic signed [WT_W-1:0] BOND_UNIT = 17'sd4096;

	// Range reduction of x = k * ln2 + r, x in Q.24.
	localparam int FRAC_W = 24;
	localparam int XR_W   = 29;
	localparam int R_W    = 24;
	localparam int K_W    = 6;
	localparam logic [X_W-1:0]  CUTOFF_Q24 = 36'd402653184;
	localparam logic [R_W-1:0]  LN2_Q24    = 24'd11629080;
	// floor(2^32 / ln2_q24); the estimate of k is exact or one low.
	localparam int              K_SHIFT    = 32;
	localparam int              K_RECIP_W  = 9;
	localparam logic [K_RECIP_W-1:0] K_RECIP = 9'd369;

	// Taylor series of exp(-r) in Q.32.
	localparam int SERIES_ORDER = 12;
	localparam int DVD_W  = 32;
	localparam int TERM_W = DVD_W + 1;
	localparam int SUM_W  = TERM_W + 2;
	localparam logic [TERM_W-1:0]        TERM_ONE = TERM_W'(64'd1 << DVD_W);
	localparam logic signed [SUM_W-1:0]  SUM_ONE  = SUM_W'(64'd1 << DVD_W);

	// floor(2^32 / n) for the division of term n by n.
	localparam logic [TERM_W-1:0] RECIP_TABLE [SERIES_ORDER] = '{
		TERM_ONE / 1, TERM_ONE / 2, TERM_ONE / 3, TERM_ONE / 4,
		TERM_ONE / 5, TERM_ONE / 6, TERM_ONE / 7, TERM_ONE / 8,
		TERM_ONE / 9, TERM_ONE / 10, TERM_ONE / 11, TERM_ONE / 12
	};

	// Side information that travels with a beat after the energy stage.
	typedef struct packed {
		logic                 center;
		logic [UNIFORM_W-1:0] uniform;
		logic                 positive;
		logic                 cutoff;
		logic [K_W-1:0]       k;
	} tag_t;

	// Beat leaving the energy stages.
	typedef struct packed {
		logic                      center;
		logic [UNIFORM_W-1:0]      uniform;
		logic signed [DELTA_W-1:0] delta;
	} delta_beat_t;

	// Beat leaving the range reduction.
	typedef struct packed {
		tag_t           tag;
		logic [R_W-1:0] r;
	} reduce_beat_t;

	// Beat leaving the series: exp(-r) in Q.32 before the shift by k.
	typedef struct packed {
		tag_t                    tag;
		logic signed [SUM_W-1:0] sum;
	} exp_beat_t;

endpackage

FILE: rtl/core/mssf_delta.sv
// Energy change of one site flip: bond terms and a two stage adder tree.
// Depends on mssf_pkg.
`timescale 1ns / 1ps

module mssf_delta (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic                                   center_spin,
	input  logic [mssf_pkg::NBR_WIDTH-1:0]         neighbor_spins,
	input  logic [mssf_pkg::NBR_WIDTH-1:0]         strong_bonds,
	input  logic [mssf_pkg::UNIFORM_W-1:0]         uniform_random,
	input  logic [mssf_pkg::COUNT_W-1:0]           neighbor_count,
	input  logic signed [mssf_pkg::COUPLING_W-1:0] coupling_j2,
	output logic                                   out_valid,
	output mssf_pkg::delta_beat_t                  out_beat
);
	import mssf_pkg::*;

	localparam int PAIRS = NBR_WIDTH / 2;

	logic [COUNT_W-1:0]           used_count;
	logic signed [WT_W-1:0]       wt [NBR_WIDTH];
	logic signed [WT_W:0]         pair_w [PAIRS];

	logic                         v_s1;
	logic signed [WT_W:0]         pair_s1 [PAIRS];
	logic                         center_s1;
	logic [UNIFORM_W-1:0]         uniform_s1;

	logic                         v_s2;
	delta_beat_t                  beat_s2;
	logic signed [DELTA_W-1:0]    delta_w;

	// Count in use: zero means one, large counts stop at the limit.
	always_comb begin
		if (neighbor_count == '0) begin
			used_count = COUNT_W'(1);
		end else if (neighbor_count > COUNT_W'(NBR_LIMIT)) begin
			used_count = COUNT_W'(NBR_LIMIT);
		end else begin
			used_count = neighbor_count;
		end
	end

	// Each bond adds its weight when the neighbor agrees with the center spin.
	always_comb begin
		for (int i = 0; i < NBR_WIDTH; i++) begin
			if (COUNT_W'(i) >= used_count) begin
				wt[i] = '0;
			end else if (neighbor_spins[i] == center_spin) begin
				wt[i] = strong_bonds[i] ? BOND_UNIT : WT_W'(coupling_j2);
			end else begin
				wt[i] = strong_bonds[i] ? -BOND_UNIT : -WT_W'(coupling_j2);
			end
		end
		for (int j = 0; j < PAIRS; j++) begin
			pair_w[j] = (WT_W + 1)'(wt[2*j]) + (WT_W + 1)'(wt[2*j+1]);
		end
	end

	// Remaining adder levels.
	always_comb begin
		delta_w = '0;
		for (int j = 0; j < PAIRS; j++) begin
			delta_w = delta_w + DELTA_W'(pair_s1[j]);
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (en) begin
			pair_s1       <= pair_w;
			center_s1     <= center_spin;
			uniform_s1    <= uniform_random;
			beat_s2.center  <= center_s1;
			beat_s2.uniform <= uniform_s1;
			beat_s2.delta   <= delta_w;
		end
	end

	assign out_valid = v_s2;
	assign out_beat  = beat_s2;

endmodule

FILE: rtl/core/mssf_reduce.sv
// Exponent argument x = 2 * beta * delta and its reduction to k * ln2 + r.
// Depends on mssf_pkg.
`timescale 1ns / 1ps

module mssf_reduce (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  mssf_pkg::delta_beat_t       in_beat,
	input  logic [mssf_pkg::BETA_W-1:0] beta,
	output logic                        out_valid,
	output mssf_pkg::reduce_beat_t      out_beat
);
	import mssf_pkg::*;

	localparam int KP_W = XR_W + K_RECIP_W;

	logic [3:0]          v_q;
	logic                positive_w;
	logic [X_W-1:0]      x_w;
	logic [KP_W-1:0]     kprod_w;
	logic [XR_W-1:0]     rr_w;
	tag_t                tag_est_w;
	tag_t                tag_fix_w;
	logic [R_W-1:0]      r_fix_w;

	logic [X_W-1:0]      x_s1;
	tag_t                tag_s1;
	logic [XR_W-1:0]     xr_s2;
	tag_t                tag_s2;
	logic [R_W:0]        rr_s3;
	tag_t                tag_s3;
	reduce_beat_t        beat_s4;

	// Stage 1: the product; only a positive delta is ever used.
	assign positive_w = (in_beat.delta > 0);
	assign x_w = (X_W'(beta) * X_W'(in_beat.delta[MAG_W-1:0])) << 1;

	// Stage 2: estimate k by a reciprocal multiply.
	assign kprod_w = KP_W'(x_s1[XR_W-1:0]) * KP_W'(K_RECIP);

	always_comb begin
		tag_est_w        = tag_s1;
		tag_est_w.cutoff = (x_s1 >= CUTOFF_Q24);
		tag_est_w.k      = kprod_w[K_SHIFT +: K_W];
	end

	// Stage 3: remainder of the estimate, below twice ln2.
	assign rr_w = xr_s2 - XR_W'(tag_s2.k) * XR_W'(LN2_Q24);

	// Stage 4: one correction step brings r below ln2.
	always_comb begin
		tag_fix_w = tag_s3;
		if (rr_s3 >= (R_W + 1)'(LN2_Q24)) begin
			r_fix_w     = R_W'(rr_s3 - (R_W + 1)'(LN2_Q24));
			tag_fix_w.k = tag_s3.k + K_W'(1);
		end else begin
			r_fix_w     = rr_s3[R_W-1:0];
		end
	end

	// Valid bits of the four stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1            <= x_w;
			tag_s1.center   <= in_beat.center;
			tag_s1.uniform  <= in_beat.uniform;
			tag_s1.positive <= positive_w;
			tag_s1.cutoff   <= 1'b0;
			tag_s1.k        <= '0;

			xr_s2           <= x_s1[XR_W-1:0];
			tag_s2          <= tag_est_w;

			rr_s3           <= rr_w[R_W:0];
			tag_s3          <= tag_s2;

			beat_s4.tag     <= tag_fix_w;
			beat_s4.r       <= r_fix_w;
		end
	end

	assign out_valid = v_q[3];
	assign out_beat  = beat_s4;

endmodule

FILE: rtl/core/mssf_series.sv
// Taylor series of exp(-r) to order twelve, three register stages per term:
// multiply by r, divide by n through a reciprocal, correct and accumulate.
// Depends on mssf_pkg.
`timescale 1ns / 1ps

module mssf_series (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  mssf_pkg::reduce_beat_t in_beat,
	output logic                   out_valid,
	output mssf_pkg::exp_beat_t    out_beat
);
	import mssf_pkg::*;

	localparam int PROD_W = TERM_W + R_W;
	localparam int QP_W   = DVD_W + TERM_W;
	localparam int REM_W  = DVD_W + 4;
	localparam int LAST   = SERIES_ORDER - 1;

	// Inputs of each term step.
	logic [SERIES_ORDER-1:0]  src_v;
	tag_t                     src_tag  [SERIES_ORDER];
	logic [R_W-1:0]           src_r    [SERIES_ORDER];
	logic [TERM_W-1:0]        src_term [SERIES_ORDER];
	logic signed [SUM_W-1:0]  src_sum  [SERIES_ORDER];

	// Logic between the stages.
	logic [PROD_W-1:0]        prod_w  [SERIES_ORDER];
	logic [QP_W-1:0]          qprod_w [SERIES_ORDER];
	logic [REM_W-1:0]         rem_w   [SERIES_ORDER];
	logic [TERM_W-1:0]        term_w  [SERIES_ORDER];
	logic signed [SUM_W-1:0]  sum_w   [SERIES_ORDER];

	// Stage registers of each step.
	logic [SERIES_ORDER-1:0]  v_s1, v_s2, v_s3;
	tag_t                     tag_s1 [SERIES_ORDER];
	tag_t                     tag_s2 [SERIES_ORDER];
	tag_t                     tag_s3 [SERIES_ORDER];
	logic [R_W-1:0]           r_s1   [SERIES_ORDER];
	logic [R_W-1:0]           r_s2   [SERIES_ORDER];
	logic [R_W-1:0]           r_s3   [SERIES_ORDER];
	logic signed [SUM_W-1:0]  sum_s1 [SERIES_ORDER];
	logic signed [SUM_W-1:0]  sum_s2 [SERIES_ORDER];
	logic signed [SUM_W-1:0]  sum_s3 [SERIES_ORDER];
	logic [DVD_W-1:0]         dvd_s1 [SERIES_ORDER];
	logic [DVD_W-1:0]         dvd_s2 [SERIES_ORDER];
	logic [DVD_W-1:0]         quo_s2 [SERIES_ORDER];
	logic [TERM_W-1:0]        term_s3 [SERIES_ORDER];

	// Chain the steps: the first one starts from term and sum equal to one.
	always_comb begin
		for (int i = 0; i < SERIES_ORDER; i++) begin
			if (i == 0) begin
				src_v[i]    = in_valid;
				src_tag[i]  = in_beat.tag;
				src_r[i]    = in_beat.r;
				src_term[i] = TERM_ONE;
				src_sum[i]  = SUM_ONE;
			end else begin
				src_v[i]    = v_s3[i-1];
				src_tag[i]  = tag_s3[i-1];
				src_r[i]    = r_s3[i-1];
				src_term[i] = term_s3[i-1];
				src_sum[i]  = sum_s3[i-1];
			end
		end
	end

	// Per step: term * r / 2^24, then the quotient estimate by n, then the
	// correction, which is at most one, and the alternating accumulation.
	always_comb begin
		for (int i = 0; i < SERIES_ORDER; i++) begin
			prod_w[i]  = PROD_W'(src_term[i]) * PROD_W'(src_r[i]);
			qprod_w[i] = QP_W'(dvd_s1[i]) * QP_W'(RECIP_TABLE[i]);
			rem_w[i]   = REM_W'(dvd_s2[i]) - REM_W'(quo_s2[i]) * REM_W'(i + 1);
			if (rem_w[i] >= REM_W'(i + 1)) begin
				term_w[i] = TERM_W'(quo_s2[i]) + TERM_W'(1);
			end else begin
				term_w[i] = TERM_W'(quo_s2[i]);
			end
			if ((i % 2) == 0) begin
				sum_w[i] = sum_s2[i] - $signed(SUM_W'(term_w[i]));
			end else begin
				sum_w[i] = sum_s2[i] + $signed(SUM_W'(term_w[i]));
			end
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= '0;
			v_s2 <= '0;
			v_s3 <= '0;
		end else if (en) begin
			v_s1 <= src_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < SERIES_ORDER; i++) begin
				dvd_s1[i]  <= prod_w[i][FRAC_W +: DVD_W];
				tag_s1[i]  <= src_tag[i];
				r_s1[i]    <= src_r[i];
				sum_s1[i]  <= src_sum[i];

				quo_s2[i]  <= qprod_w[i][DVD_W +: DVD_W];
				dvd_s2[i]  <= dvd_s1[i];
				tag_s2[i]  <= tag_s1[i];
				r_s2[i]    <= r_s1[i];
				sum_s2[i]  <= sum_s1[i];

				term_s3[i] <= term_w[i];
				sum_s3[i]  <= sum_w[i];
				tag_s3[i]  <= tag_s2[i];
				r_s3[i]    <= r_s2[i];
			end
		end
	end

	assign out_valid    = v_s3[LAST];
	assign out_beat.tag = tag_s3[LAST];
	assign out_beat.sum = sum_s3[LAST];

endmodule

FILE: rtl/core/metropolis_spin_flip_decision.sv
// Metropolis single spin flip decision: one result beat per input beat.
// Throughput: one item per cycle while in_stall is low; most of the depth comes
// from the twelve series terms, three stages each, after two energy and four range
// reduction stages.
// Reset clears all valid bits and loads the register reset values.
// Depends on mssf_pkg, mssf_delta, mssf_reduce, mssf_series and the assert header.
`timescale 1ns / 1ps
`include "metropolis_spin_flip_decision_assert.svh"

module metropolis_spin_flip_decision (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mssf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mssf_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                center_spin,
	input  logic [mssf_pkg::NBR_WIDTH-1:0]      neighbor_spins,
	input  logic [mssf_pkg::NBR_WIDTH-1:0]      strong_bonds,
	input  logic [mssf_pkg::UNIFORM_W-1:0]      uniform_random,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                new_spin,
	output logic                                flipped,
	output logic                                random_used
);
	import mssf_pkg::*;

	localparam int RND_W = TERM_W + 1;

	typedef struct packed {
		logic new_spin;
		logic flipped;
		logic random_used;
	} result_t;

	// Configuration registers.
	logic [COUNT_W-1:0]           neighbor_count_q;
	logic signed [COUPLING_W-1:0] coupling_j2_q;
	logic [BETA_W-1:0]            inverse_temperature_q;

	// Pipeline enable: everything moves unless the skid buffer is holding a beat.
	logic                         en;

	logic                         delta_valid;
	delta_beat_t                  delta_beat;
	logic                         reduce_valid;
	reduce_beat_t                 reduce_beat;
	logic                         exp_valid;
	exp_beat_t                    exp_beat;

	// Final shift by k and comparison.
	logic [TERM_W-1:0]            clamp_w;
	logic [RND_W-1:0]             rnd_w;
	logic                         v_s1, v_s2;
	logic [RND_W-1:0]             rnd_s1;
	tag_t                         tag_s1;
	logic [TERM_W-1:0]            p_s2;
	tag_t                         tag_s2;
	logic                         flip_w;
	result_t                      result_w;
	logic                         take;

	// Output register and skid buffer.
	logic                         out_valid_q;
	result_t                      out_q;
	logic                         skid_valid_q;
	result_t                      skid_q;
	logic                         out_ready;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neighbor_count_q      <= COUNT_RESET;
			coupling_j2_q         <= COUPLING_RESET;
			inverse_temperature_q <= BETA_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NEIGHBOR_COUNT: neighbor_count_q      <= cfg_data[COUNT_W-1:0];
				CFG_COUPLING_J2:    coupling_j2_q         <= cfg_data[COUPLING_W-1:0];
				CFG_INVERSE_TEMP:   inverse_temperature_q <= cfg_data[BETA_W-1:0];
				default: ;
			endcase
		end
	end

	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;

	mssf_delta u_delta (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (in_valid),
		.center_spin    (center_spin),
		.neighbor_spins (neighbor_spins),
		.strong_bonds   (strong_bonds),
		.uniform_random (uniform_random),
		.neighbor_count (neighbor_count_q),
		.coupling_j2    (coupling_j2_q),
		.out_valid      (delta_valid),
		.out_beat       (delta_beat)
	);

	mssf_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (delta_valid),
		.in_beat   (delta_beat),
		.beta      (inverse_temperature_q),
		.out_valid (reduce_valid),
		.out_beat  (reduce_beat)
	);

	mssf_series u_series (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (reduce_valid),
		.in_beat   (reduce_beat),
		.out_valid (exp_valid),
		.out_beat  (exp_beat)
	);

	// Clamp the series sum at zero and add half of the last place shifted out.
	always_comb begin
		clamp_w = exp_beat.sum[SUM_W-1] ? '0 : exp_beat.sum[TERM_W-1:0];
		if (exp_beat.tag.k == '0) begin
			rnd_w = RND_W'(clamp_w);
		end else begin
			rnd_w = RND_W'(clamp_w) + (RND_W'(1) << (exp_beat.tag.k - K_W'(1)));
		end
	end

	// Flip on a delta that is not positive, else when the draw is below p.
	always_comb begin
		flip_w               = !tag_s2.positive || ({1'b0, tag_s2.uniform} < p_s2);
		result_w.new_spin    = tag_s2.center ^ flip_w;
		result_w.flipped     = flip_w;
		result_w.random_used = tag_s2.positive;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= exp_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rnd_s1 <= rnd_w;
			tag_s1 <= exp_beat.tag;
			p_s2   <= tag_s1.cutoff ? '0 : TERM_W'(rnd_s1 >> tag_s1.k);
			tag_s2 <= tag_s1;
		end
	end

	// Output register with a one beat skid buffer behind it.
	assign take      = en && v_s2;
	assign out_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= take;
			end
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (take) begin
				out_q <= result_w;
			end
		end else if (take) begin
			skid_q <= result_w;
		end
	end

	assign out_valid   = out_valid_q;
	assign new_spin    = out_q.new_spin;
	assign flipped     = out_q.flipped;
	assign random_used = out_q.random_used;

	// The skid buffer only fills behind a stalled output beat.
	`MSSF_ASSERT(a_skid_behind_out, clk, arst_n, skid_valid_q |-> out_valid_q)
	`MSSF_ASSERT(a_skid_fill_on_stall, clk, arst_n, $rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
	// A result that did not use the draw is always a flip.
	`MSSF_ASSERT(a_sure_flip, clk, arst_n, (out_valid && !random_used) |-> flipped)
	// The probability after the shift never exceeds one.
	`MSSF_ASSERT_NEVER(a_prob_range, clk, arst_n, v_s2 && tag_s2.positive && (p_s2 > TERM_ONE))

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the Metropolis spin flip decision block.
// Drives directed and random beats through several register settings and checks every
// result beat against a built-in predictor. Depends on mssf_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
	import mssf_pkg::*;

	localparam int     PIPE_LATENCY = 44;
	localparam int     CYCLE_LIMIT  = 400000;
	localparam int     LONG_HOLD    = 200;
	localparam longint UNIT_BOND    = 64'sd4096;
	localparam longint LN2_FIX      = 64'sd11629080;
	localparam longint EXP_CUTOFF   = 64'sd24 <<< 24;
	localparam longint PROB_ONE     = 64'sd1 <<< 32;
	localparam longint UNIFORM_MAX  = 64'sd4294967295;
	localparam int     TAYLOR_TERMS = 12;

	typedef struct packed {
		bit new_spin;
		bit flipped;
		bit random_used;
	} decision_t;

	// Holds a copy of the registers and the decisions still owed by the block.
	class flip_scoreboard;
		logic [3:0]         nbr_count;
		logic signed [15:0] weak_bond;
		logic [15:0]        beta_q12;
		decision_t          expected_decisions[$];
		int unsigned        mismatches;
		int unsigned        beats_seen;

		function new();
			nbr_count  = COUNT_RESET;
			weak_bond  = COUPLING_RESET;
			beta_q12   = BETA_RESET;
			mismatches = 0;
			beats_seen = 0;
		endfunction

		function void write_reg(cfg_index_t idx, logic [15:0] data);
			case (idx)
				CFG_NEIGHBOR_COUNT: nbr_count = data[3:0];
				CFG_COUPLING_J2:    weak_bond = data;
				CFG_INVERSE_TEMP:   beta_q12  = data;
				default: ;
			endcase
		endfunction

		// Energy change of a flip in Q8.12; a zero count still uses neighbor 0.
		function longint energy_change(bit cs, bit [7:0] ns, bit [7:0] sb);
			int     used;
			longint sum;
			longint w;
			used = int'(nbr_count);
			if (used < 1)
				used = 1;
			if (used > NBR_LIMIT)
				used = NBR_LIMIT;
			sum = 0;
			for (int i = 0; i < used; i++) begin
				w = sb[i] ? UNIT_BOND : longint'(weak_bond);
				sum += ns[i] ? w : -w;
			end
			return cs ? sum : -sum;
		endfunction

		// Flip probability exp(-2*beta*delta) in Q.32 for a positive delta.
		function longint acceptance_q32(longint delta);
			longint x;
			longint k;
			longint r;
			longint term;
			longint acc;
			x = 2 * longint'(beta_q12) * delta;
			if (x >= EXP_CUTOFF)
				return 0;
			k    = x / LN2_FIX;
			r    = x - k * LN2_FIX;
			term = PROB_ONE;
			acc  = term;
			for (int n = 1; n <= TAYLOR_TERMS; n++) begin
				term = (term * r) / (longint'(n) << 24);
				if (n % 2)
					acc -= term;
				else
					acc += term;
			end
			if (acc < 0)
				acc = 0;
			if (k == 0)
				return acc;
			return (acc + (longint'(1) << (k - 1))) >> k;
		endfunction

		function void note_input(bit cs, bit [7:0] ns, bit [7:0] sb, bit [31:0] u);
			decision_t d;
			longint    delta;
			delta         = energy_change(cs, ns, sb);
			d.random_used = (delta > 0);
			if (delta <= 0)
				d.flipped = 1'b1;
			else
				d.flipped = (longint'(u) < acceptance_q32(delta));
			d.new_spin = cs ^ d.flipped;
			expected_decisions.push_back(d);
		endfunction

		function int pending();
			return expected_decisions.size();
		endfunction

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= 40)
				$display("mismatch at %0t, result beat %0d: %s", $time, beats_seen, what);
		endtask

		task check_result(logic got_spin, logic got_flip, logic got_used);
			decision_t want;
			beats_seen++;
			if (expected_decisions.size() == 0) begin
				report_mismatch("result beat with no decision pending");
			end else begin
				want = expected_decisions.pop_front();
				if (got_spin !== want.new_spin)
					report_mismatch($sformatf("new_spin %b, expected %b", got_spin, want.new_spin));
				if (got_flip !== want.flipped)
					report_mismatch($sformatf("flipped %b, expected %b", got_flip, want.flipped));
				if (got_used !== want.random_used)
					report_mismatch($sformatf("random_used %b, expected %b",
						got_used, want.random_used));
			end
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic                   center_spin;
	logic [NBR_WIDTH-1:0]   neighbor_spins;
	logic [NBR_WIDTH-1:0]   strong_bonds;
	logic [UNIFORM_W-1:0]   uniform_random;
	logic                   out_valid;
	logic                   out_stall;
	logic                   new_spin;
	logic                   flipped;
	logic                   random_used;

	flip_scoreboard flip_board = new();

	bit idle_allowed  = 1'b1;
	bit gaps_on       = 1'b0;
	bit stalls_on     = 1'b0;
	bit long_hold_req = 1'b0;

	metropolis_spin_flip_decision i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.center_spin    (center_spin),
		.neighbor_spins (neighbor_spins),
		.strong_bonds   (strong_bonds),
		.uniform_random (uniform_random),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.new_spin       (new_spin),
		.flipped        (flipped),
		.random_used    (random_used)
	);

	// Free-running clock, 8 ns period.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Result beats are taken at the rising edge when valid and not stalled.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			flip_board.check_result(new_spin, flipped, random_used);
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin : stall_driver
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall <= 1'b0;
			end else if (stalls_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Ends the run with a failure once the cycle limit is reached.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// Offers one input beat and holds it until the block accepts it.
	task automatic send_item(bit cs, bit [7:0] ns, bit [7:0] sb, bit [31:0] u);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid       <= 1'b1;
		center_spin    <= cs;
		neighbor_spins <= ns;
		strong_bonds   <= sb;
		uniform_random <= u;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		flip_board.note_input(cs, ns, sb, u);
		@(negedge clk);
	endtask

	// Places the uniform value at, just below or just above the flip threshold.
	task automatic send_at_threshold(bit cs, bit [7:0] ns, bit [7:0] sb, longint offset);
		longint v;
		v = offset;
		if (flip_board.energy_change(cs, ns, sb) > 0)
			v += flip_board.acceptance_q32(flip_board.energy_change(cs, ns, sb));
		if (v < 0)
			v = 0;
		if (v > UNIFORM_MAX)
			v = UNIFORM_MAX;
		send_item(cs, ns, sb, v[31:0]);
	endtask

	task automatic send_random();
		bit       cs;
		bit [7:0] ns;
		bit [7:0] sb;
		bit [31:0] u;
		cs = 1'($urandom_range(0, 1));
		ns = 8'($urandom);
		sb = 8'($urandom);
		case ($urandom_range(0, 9))
			0: u = '0;
			1: u = '1;
			default: u = $urandom;
		endcase
		if ($urandom_range(0, 99) < 40)
			send_at_threshold(cs, ns, sb, longint'($urandom_range(0, 2)) - 1);
		else
			send_item(cs, ns, sb, u);
	endtask

	// Waits until every owed result beat has arrived and the pipeline is empty.
	task automatic drain();
		in_valid <= 1'b0;
		while (flip_board.pending() != 0)
			@(negedge clk);
		repeat (PIPE_LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		flip_board.write_reg(idx, data);
		@(negedge clk);
	endtask

	// Unused upper bits of the count write carry junk that must be ignored.
	task automatic configure(logic [3:0] count, logic signed [15:0] j2, logic [15:0] beta);
		drain();
		write_reg(CFG_NEIGHBOR_COUNT, {12'($urandom), count});
		write_reg(CFG_COUPLING_J2, j2);
		write_reg(CFG_INVERSE_TEMP, beta);
	endtask

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 16 == 0 && idle_allowed) begin
				gaps_on   = $urandom_range(0, 2) != 0;
				stalls_on = $urandom_range(0, 2) != 0;
			end
			send_random();
		end
	endtask

	initial begin : stimulus
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_NEIGHBOR_COUNT;
		cfg_data       = '0;
		in_valid       = 1'b0;
		center_spin    = 1'b0;
		neighbor_spins = '0;
		strong_bonds   = '0;
		uniform_random = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: zero delta, both signs, upper neighbors ignored, threshold edges.
		send_item(1'b0, 8'h00, 8'h00, 32'h0000_0000);
		send_item(1'b1, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
		send_item(1'b1, 8'hFF, 8'hFF, 32'h0000_0000);
		send_item(1'b0, 8'hFF, 8'hFF, $urandom);
		send_item(1'b0, 8'hF0, 8'hFF, 32'hFFFF_FFFF);
		send_at_threshold(1'b1, 8'h01, 8'h01, -1);
		send_at_threshold(1'b1, 8'h01, 8'h01, 0);

		// A zero count behaves as a single neighbor.
		configure(4'd0, 16'sd0, 16'd4096);
		send_item(1'b1, 8'h01, 8'hFF, 32'h0000_0000);
		send_item(1'b1, 8'hFE, 8'hFF, 32'hFFFF_FFFF);

		// Count above the limit is clamped; strongest weak bond, largest beta.
		configure(4'd15, -16'sd32768, 16'd65535);
		send_item(1'b1, 8'hFF, 8'h00, 32'h0000_0000);
		send_item(1'b0, 8'hFF, 8'h00, 32'h0000_0000);
		send_item(1'b0, 8'h00, 8'hFF, 32'h0000_0000);

		// Zero beta gives probability one: even the largest uniform value flips.
		configure(4'd8, 16'sd32767, 16'd0);
		send_item(1'b1, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
		send_item(1'b0, 8'h55, 8'hAA, $urandom);

		// Tiny weak bond keeps the exponent small, so the series does the work.
		configure(4'd8, 16'sd1, 16'd4096);
		send_at_threshold(1'b1, 8'h01, 8'h00, 0);
		send_at_threshold(1'b1, 8'h01, 8'h00, -1);
		send_at_threshold(1'b0, 8'h7F, 8'h80, 1);
		send_item(1'b1, 8'h80, 8'h80, $urandom);

		configure(4'd4, 16'sh0800, 16'd2048);
		run_random(40);
		configure(4'd8, -16'sd4096, 16'd1024);
		run_random(40);

		// Long receiver hold-off while the sender keeps offering beats back to back.
		gaps_on       = 1'b0;
		stalls_on     = 1'b0;
		long_hold_req = 1'b1;
		for (int i = 0; i < 120; i++)
			send_random();

		configure(4'd1, 16'sd32767, 16'd256);
		run_random(40);
		configure(4'd15, -16'sd32768, 16'd65535);
		run_random(40);
		configure(4'd0, 16'sd300, 16'd0);
		run_random(40);
		configure(4'd6, 16'($urandom), 16'($urandom_range(0, 8191)));
		run_random(40);
		configure(4'd8, -16'sd2000, 16'd3000);
		run_random(40);

		// Final stretch with neither side idling; stalls stop before the drain.
		idle_allowed = 1'b0;
		gaps_on      = 1'b0;
		stalls_on    = 1'b0;
		configure(4'd4, 16'sh0400, 16'd4096);
		run_random(40);

		drain();
		if (flip_board.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
